FILE: sv/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console character engine - shared definitions
// Cell buffer geometry, character codes, register indexes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int MaxCells = 8192;
  localparam int AddrW    = $clog2(MaxCells);
  localparam int CurW     = AddrW + 1;          // cursor may overshoot before wrap
  localparam int DvdW     = $clog2(MaxCells) + 1; // holds MaxCells itself
  localparam int DivSteps = DvdW;
  localparam int StepW    = $clog2(DivSteps);
  localparam int TotW     = 16;                 // columns x rows product

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [3:0] TabStop  = 4'd8;

  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_ATTR    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    DIV_CURSOR   = 1'b0,
    DIV_CAPACITY = 1'b1
  } div_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GEOM,
    S_MUL,
    S_CHECK,
    S_RDIV,
    S_RLIM,
    S_CLAMP,
    S_DINIT,
    S_DIV,
    S_APPLY,
    S_WRAP,
    S_COPY,
    S_ZERO,
    S_CLEAR,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     in_load;
    logic     geom_load;
    logic     mul_load;
    logic     rlim_load;
    logic     div_start;
    div_src_t div_src;
    logic     div_step;
    logic     clamp;
    logic     cnt_clr;
    logic     apply;
    logic     wrap;
    logic     copy;
    logic     zero;
    logic     fill;
    logic     rd_issue;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic need_mod;   // put of LF, HT or CR: needs cursor modulo columns
    logic big;        // columns x rows beyond capacity
    logic div_last;
    logic ovf;        // cursor past the last screen cell
    logic copy_end;
    logic fill_end;
    logic out_free;
  } stat_t;

endpackage

FILE: sv/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// Text console character engine - controller
// Sequences geometry set-up, cursor division, cell update, scroll, clear and
// read for one request at a time.
// ----------------------------------------------------------------------------
module tcce_ctrl import tcce_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_GEOM;
      S_GEOM:  state_next = S_MUL;
      S_MUL:   state_next = S_CHECK;
      S_CHECK: state_next = stat.big ? S_RDIV : S_CLAMP;
      S_RDIV:  if (stat.div_last) state_next = S_RLIM;
      S_RLIM:  state_next = S_MUL;
      S_CLAMP: begin
        case (stat.op)
          OP_PUT:   state_next = stat.need_mod ? S_DINIT : S_APPLY;
          OP_CLEAR: state_next = S_CLEAR;
          OP_READ:  state_next = S_READ;
          default:  state_next = S_DONE;
        endcase
      end
      S_DINIT: state_next = S_DIV;
      S_DIV:   if (stat.div_last) state_next = S_APPLY;
      S_APPLY: state_next = S_WRAP;
      S_WRAP:  state_next = stat.ovf ? S_COPY : S_DONE;
      S_COPY:  if (stat.copy_end) state_next = S_ZERO;
      S_ZERO:  if (stat.fill_end) state_next = S_DONE;
      S_CLEAR: if (stat.fill_end) state_next = S_DONE;
      S_READ:  state_next = S_DONE;
      S_DONE:  if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
      end
      S_GEOM:  cmd.geom_load = 1'b1;
      S_MUL:   cmd.mul_load  = 1'b1;
      S_CHECK: begin
        cmd.div_start = stat.big;
        cmd.div_src   = DIV_CAPACITY;
      end
      S_RDIV:  cmd.div_step  = 1'b1;
      S_RLIM:  cmd.rlim_load = 1'b1;
      S_CLAMP: begin
        cmd.clamp   = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      S_DINIT: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_CURSOR;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_APPLY: cmd.apply    = 1'b1;
      S_WRAP: begin
        cmd.wrap    = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      S_COPY:  cmd.copy     = 1'b1;
      S_ZERO:  cmd.zero     = 1'b1;
      S_CLEAR: cmd.fill     = 1'b1;
      S_READ:  cmd.rd_issue = 1'b1;
      S_DONE: begin
        // keep the read address so a stalled result still sees the cell
        cmd.rd_issue = (stat.op == OP_READ);
        cmd.res_load = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: sv/tcce_dp.sv
// ----------------------------------------------------------------------------
// Text console character engine - datapath
// Configuration registers, geometry, cursor, shift-subtract divider, cell
// buffer memory and the result register.
// ----------------------------------------------------------------------------
module tcce_dp import tcce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_char_code,
  input  logic [12:0] in_cell_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] out_cursor_pos,
  output logic [15:0] out_cell_word,
  output logic        out_scrolled
);

  logic [7:0]       columns, rows, attribute;
  op_t              op_q;
  logic [7:0]       ch_q;
  logic [AddrW-1:0] idx_q;
  logic [7:0]       eff_c, eff_r, attr_q;
  logic [TotW-1:0]  total;
  logic [CurW-1:0]  cursor;
  logic [DvdW-1:0]  dvd;
  logic [7:0]       rem;
  logic [StepW-1:0] dcnt;
  logic [AddrW-1:0] cnt;
  logic             scrolled;

  logic [15:0]      mem [MaxCells];
  logic [15:0]      rdata;
  logic             we;
  logic [AddrW-1:0] wa, ra;
  logic [15:0]      wd;

  logic [8:0]       rem_sh, rem_sub;
  logic             rem_ge;
  logic [CurW-1:0]  c_ext, nc, back;
  logic [TotW-1:0]  keep, last_cell;
  logic             is_ctrl;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      columns   <= 8'd80;
      rows      <= 8'd25;
      attribute <= 8'd7;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COLUMNS: columns   <= cfg_data;
        CFG_ROWS:    rows      <= cfg_data;
        CFG_ATTR:    attribute <= cfg_data;
        default:     ;
      endcase
    end
  end

  // request fields and geometry
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_q  <= op_t'(in_opcode);
      ch_q  <= in_char_code;
      idx_q <= in_cell_index[AddrW-1:0];
    end
    if (cmd.geom_load) begin
      eff_c  <= (columns == 8'd0) ? 8'd1 : columns;
      eff_r  <= (rows == 8'd0) ? 8'd1 : rows;
      attr_q <= attribute;
    end else if (cmd.rlim_load) begin
      eff_r <= dvd[7:0];
    end
    if (cmd.mul_load) total <= eff_c * eff_r;
  end

  assign c_ext     = CurW'(eff_c);
  assign keep      = total - TotW'(eff_c);
  assign last_cell = total - TotW'(1);

  // divider: one quotient bit a cycle, remainder stays below columns
  assign rem_sh  = {rem, dvd[DvdW-1]};
  assign rem_ge  = rem_sh >= {1'b0, eff_c};
  assign rem_sub = rem_sh - {1'b0, eff_c};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd  <= (cmd.div_src == DIV_CAPACITY) ? DvdW'(MaxCells) : DvdW'(cursor);
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dvd  <= {dvd[DvdW-2:0], rem_ge};
      rem  <= rem_ge ? rem_sub[7:0] : rem_sh[7:0];
      dcnt <= dcnt + StepW'(1);
    end
  end

  // cursor move for a put
  assign is_ctrl = ch_q inside {CH_NUL, CH_BS, CH_HT, CH_LF, CH_VT, CH_CR};
  assign back    = (cursor == '0) ? '0 : cursor - CurW'(1);

  always_comb begin
    case (ch_q)
      CH_LF:   nc = cursor + c_ext - CurW'(rem);
      CH_HT:   nc = cursor + CurW'(TabStop - {1'b0, rem[2:0]});
      CH_VT:   nc = cursor + c_ext;
      CH_CR:   nc = cursor - CurW'(rem);
      CH_NUL:  nc = cursor;
      CH_BS:   nc = back;
      default: nc = cursor + CurW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (cmd.clamp) begin
      if (TotW'(cursor) >= total) cursor <= CurW'(last_cell);
    end else if (cmd.apply) begin
      cursor <= nc;
    end else if (cmd.wrap) begin
      if (TotW'(cursor) >= total) begin
        // far tab on very narrow screens can still be past the end
        if (TotW'(cursor - c_ext) >= total) cursor <= CurW'(last_cell);
        else                                 cursor <= cursor - c_ext;
      end
    end else if (cmd.fill) begin
      cursor <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) scrolled <= 1'b0;
    else if (cmd.wrap && TotW'(cursor) >= total) scrolled <= 1'b1;
  end

  // sweep counter for scroll copy, bottom row zeroing and clear
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.copy) begin
      if (!stat.copy_end) cnt <= cnt + AddrW'(1);
    end else if (cmd.zero || cmd.fill) begin
      cnt <= cnt + AddrW'(1);
    end
  end

  // memory port selection; a copy writes the word read in the cycle before
  always_comb begin
    we = 1'b0;
    wa = cnt;
    wd = '0;
    ra = AddrW'(TotW'(cnt) + TotW'(eff_c));
    if (cmd.apply) begin
      we = (ch_q == CH_BS) || !is_ctrl;
      wa = (ch_q == CH_BS) ? nc[AddrW-1:0] : cursor[AddrW-1:0];
      wd = {attr_q, (ch_q == CH_BS) ? CH_SPACE : ch_q};
    end else if (cmd.copy) begin
      we = cnt != '0;
      wa = cnt - AddrW'(1);
      wd = rdata;
    end else if (cmd.zero) begin
      we = 1'b1;
    end else if (cmd.fill) begin
      we = 1'b1;
      wd = {attr_q, CH_SPACE};
    end
    if (cmd.rd_issue) ra = idx_q;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[ra];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_cursor_pos <= 13'(cursor);
      out_cell_word  <= (op_q == OP_READ) ? rdata : 16'd0;
      out_scrolled   <= scrolled;
    end
  end

  assign stat.op       = op_q;
  assign stat.need_mod = (ch_q == CH_LF) || (ch_q == CH_HT) || (ch_q == CH_CR);
  assign stat.big      = total > TotW'(MaxCells);
  assign stat.div_last = dcnt == StepW'(DivSteps - 1);
  assign stat.ovf      = TotW'(cursor) >= total;
  assign stat.copy_end = TotW'(cnt) == keep;
  assign stat.fill_end = TotW'(cnt) == last_cell;
  assign stat.out_free = !out_valid || out_ready;

endmodule

FILE: sv/text_console_char_engine_core.sv
// ----------------------------------------------------------------------------
// Text console character engine - top level
// Put character, clear screen and read cell requests on a cell buffer.
// ----------------------------------------------------------------------------
// Every request passes geometry set-up and clamp; clear then fills columns x rows
// cells, LF, HT and CR run the one-bit-a-cycle column divider, a scroll copies
// and blanks rows, and geometry beyond capacity first limits rows by division.
// One request in flight; the next is taken the cycle after the result is registered.
// Reset: cursor 0, columns 80, rows 25, attribute 7; buffer is not cleared.
module text_console_char_engine_core import tcce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], cell_index[20:8], zero pad
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cursor_pos[12:0], cell_word[28:13], scrolled[29]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cmd_t        cmd;
  stat_t       stat;
  logic [12:0] cursor_pos;
  logic [15:0] cell_word;
  logic        scrolled;

  assign cfg_ready = 1'b1;

  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcce_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (s_tuser),
    .in_char_code   (s_tdata[7:0]),
    .in_cell_index  (s_tdata[20:8]),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_cursor_pos (cursor_pos),
    .out_cell_word  (cell_word),
    .out_scrolled   (scrolled)
  );

  assign m_tdata = {2'b00, scrolled, cell_word, cursor_pos};

endmodule

FILE: sv/tcce_chk.sv
// ----------------------------------------------------------------------------
// Text console character engine - port checker
// Assertions on the stream and result behaviour seen at the top level.
// ----------------------------------------------------------------------------
module tcce_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [7:0]  cfg_data
);

  // one request in flight: no second request straight after the first
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while previous one in progress");

  // a result never appears in the cycle right after its request
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result too early after request");

  // a scrolling put carries no cell word
  a_scroll_no_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[29]) |-> (m_tdata[28:13] == 16'd0))
    else $error("scrolled result with non-zero cell word");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind text_console_char_engine_core tcce_chk u_tcce_chk (.*);

FILE: tb/console_result_checker.sv
// ----------------------------------------------------------------------------
// Text console character engine - result checker
// Watches the request, result and register write channels, keeps its own copy
// of the cell buffer, cursor and geometry, predicts one result per request and
// compares each returned result field by field in arrival order.
// ----------------------------------------------------------------------------
module console_result_checker import tcce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], cell_index[20:8], zero pad
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // cursor_pos[12:0], cell_word[28:13], scrolled[29]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          awaiting,
  output int          fault_total
);

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [AddrW-1:0] cursor_pos;
    logic [15:0]      cell_word;
    logic             scrolled;
  } console_result_t;

  logic [15:0]      cells [0:MaxCells-1];
  logic [AddrW-1:0] cursor;
  logic [7:0]       col_cfg;
  logic [7:0]       row_cfg;
  logic [7:0]       attr_cfg;
  console_result_t  pending_results [$];
  console_result_t  want;
  int               faults = 0;

  function automatic void flag_fault(string field, int unsigned exp_v, int unsigned got_v);
    faults++;
    if (faults <= ReportLimit)
      $display("[%0t] %s mismatch: expected %0h, got %0h", $time, field, exp_v, got_v);
  endfunction

  function automatic console_result_t console_step(op_t op, logic [7:0] ch,
                                                   logic [AddrW-1:0] idx);
    int unsigned     c;
    int unsigned     r;
    int unsigned     total;
    int unsigned     pos;
    int unsigned     keep;
    int unsigned     i;
    logic [15:0]     blank;
    console_result_t res;
    c = (col_cfg == 0) ? 1 : col_cfg;
    r = (row_cfg == 0) ? 1 : row_cfg;
    if (c * r > MaxCells) r = MaxCells / c;
    total = c * r;
    blank = {attr_cfg, CH_SPACE};
    res   = '0;
    pos   = cursor;
    // geometry may have shrunk under the cursor
    if (pos >= total) pos = total - 1;
    case (op)
      OP_PUT: begin
        case (ch)
          CH_LF:  pos = pos + c - pos % c;
          CH_BS: begin
            if (pos > 0) pos--;
            cells[pos] = blank;
          end
          CH_HT:  pos = pos + TabStop - (pos % c) % TabStop;
          CH_VT:  pos = pos + c;
          CH_CR:  pos = pos - pos % c;
          CH_NUL: ;
          default: begin
            cells[pos] = {attr_cfg, ch};
            pos++;
          end
        endcase
        if (pos > total - 1) begin
          pos  = pos - c;
          keep = (r - 1) * c;
          for (i = 0; i < keep; i++) cells[i] = cells[i + c];
          for (i = keep; i < total; i++) cells[i] = '0;
          res.scrolled = 1'b1;
          // a tab on a very narrow screen can still overshoot
          if (pos > total - 1) pos = total - 1;
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < total; i++) cells[i] = blank;
        pos = 0;
      end
      OP_READ: res.cell_word = cells[idx];
      default: ;
    endcase
    cursor         = pos[AddrW-1:0];
    res.cursor_pos = pos[AddrW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pending_results.delete();
      cursor   = '0;
      col_cfg  = 8'd80;
      row_cfg  = 8'd25;
      attr_cfg = 8'd7;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          faults++;
          if (faults <= ReportLimit)
            $display("[%0t] result %0h with no request pending", $time, m_tdata);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[12:0] !== want.cursor_pos)
            flag_fault("cursor_pos", want.cursor_pos, m_tdata[12:0]);
          if (m_tdata[28:13] !== want.cell_word)
            flag_fault("cell_word", want.cell_word, m_tdata[28:13]);
          if (m_tdata[29] !== want.scrolled)
            flag_fault("scrolled", want.scrolled, m_tdata[29]);
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(console_step(op_t'(s_tuser), s_tdata[7:0],
                                               s_tdata[20:8]));
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_COLUMNS: col_cfg  = cfg_data;
          CFG_ROWS:    row_cfg  = cfg_data;
          CFG_ATTR:    attr_cfg = cfg_data;
          default: ;
        endcase
      end
    end
    awaiting    <= pending_results.size();
    fault_total <= faults;
  end

endmodule

FILE: tb/text_console_char_engine_core_tb.sv
// ----------------------------------------------------------------------------
// Text console character engine - testbench top
// Drives put, clear, read and no-op requests through a series of screen
// geometries and attributes with random gaps on both channels; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module text_console_char_engine_core_tb;
  import tcce_pkg::*;

  localparam int CycleLimit = 3000000;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;

  int awaiting;
  int fault_total;
  int cycle_count    = 0;
  int sink_hold      = 0;
  int steady_left    = 0;
  int readable_cells = 0;

  text_console_char_engine_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  console_result_checker u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .awaiting(awaiting), .fault_total(fault_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("text_console_char_engine_core_tb NOT OK");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result sink back-pressure, with occasional long stretches of ready
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (m_tready && $urandom_range(0, 99) < 30) begin
      m_tready  <= 1'b0;
      sink_hold <= idle_len();
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < 3) sink_hold <= $urandom_range(50, 200);
    end
  end

  task automatic issue(op_t op, logic [7:0] ch, logic [AddrW-1:0] idx);
    int gap;
    if (steady_left > 0) begin
      steady_left--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 99) < 3) steady_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, idx, ch};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(cfg_idx_t which, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic reconfigure(logic [7:0] cols, logic [7:0] rows, logic [7:0] attr);
    settle();
    write_reg(CFG_COLUMNS, cols);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_ATTR, attr);
  endtask

  task automatic random_requests(int count);
    op_t              op;
    logic [7:0]       ch;
    logic [AddrW-1:0] idx;
    int               roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 62)      op = OP_PUT;
      else if (roll < 64) op = OP_CLEAR;
      else if (roll < 90) op = OP_READ;
      else                op = OP_NOP;
      if ($urandom_range(0, 99) < 45) begin
        case ($urandom_range(0, 5))
          0:       ch = CH_NUL;
          1:       ch = CH_BS;
          2:       ch = CH_HT;
          3:       ch = CH_LF;
          4:       ch = CH_VT;
          default: ch = CH_CR;
        endcase
      end else begin
        ch = 8'($urandom_range(0, 255));
      end
      // reads stay on cells known to have been written
      if (op == OP_READ) idx = AddrW'($urandom_range(0, readable_cells - 1));
      else               idx = AddrW'($urandom);
      issue(op, ch, idx);
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry 80 x 25
    issue(OP_CLEAR, 8'hFF, 13'h1FFF);
    readable_cells = 80 * 25;
    issue(OP_PUT, CH_BS, 13'h0000);     // backspace at home
    issue(OP_PUT, 8'h41, 13'h0000);
    issue(OP_PUT, 8'hFF, 13'h0000);
    issue(OP_PUT, 8'h80, 13'h0000);
    issue(OP_PUT, 8'h7F, 13'h0000);
    issue(OP_PUT, CH_NUL, 13'h0000);
    issue(OP_PUT, CH_HT, 13'h0000);
    issue(OP_PUT, CH_BS, 13'h0000);
    issue(OP_PUT, CH_LF, 13'h0000);
    issue(OP_PUT, CH_VT, 13'h0000);
    issue(OP_PUT, 8'h01, 13'h0000);
    issue(OP_PUT, CH_CR, 13'h0000);
    issue(OP_READ, 8'h00, 13'd0);
    issue(OP_READ, 8'hFF, 13'd1);
    issue(OP_READ, 8'h00, 13'd1999);
    issue(OP_NOP, 8'hFF, 13'h1FFF);
    random_requests(40);

    // too tall: rows limited to capacity, and this clear writes every cell
    reconfigure(8'd128, 8'd255, 8'hFF);
    issue(OP_CLEAR, 8'h00, 13'h0000);
    readable_cells = MaxCells;
    random_requests(12);

    reconfigure(8'd16, 8'd4, 8'h00);
    random_requests(110);
    reconfigure(8'd3, 8'd2, 8'hA5);     // narrower than a tab stop
    random_requests(110);
    reconfigure(8'd1, 8'd255, 8'h5A);
    random_requests(100);
    reconfigure(8'd0, 8'd0, 8'h80);     // zero geometry, cursor pulled back
    random_requests(60);
    reconfigure(8'd255, 8'd1, 8'h01);   // single row
    random_requests(100);
    reconfigure(8'd1, 8'd1, 8'h7E);
    random_requests(60);
    reconfigure(8'd40, 8'd10, 8'h3C);
    random_requests(110);
    reconfigure(8'd255, 8'd255, 8'hC3);
    random_requests(12);
    reconfigure(8'd8, 8'd8, 8'h07);
    random_requests(80);

    settle();
    repeat (40) @(posedge clk);
    if (fault_total == 0) $display("text_console_char_engine_core_tb OK");
    else $display("text_console_char_engine_core_tb NOT OK");
    $finish;
  end

endmodule

FILE: text_console_char_engine_core.f
sv/tcce_pkg.sv
sv/tcce_ctrl.sv
sv/tcce_dp.sv
sv/text_console_char_engine_core.sv
sv/tcce_chk.sv
tb/console_result_checker.sv
tb/text_console_char_engine_core_tb.sv
